### rtl/sfs_pkg.sv
// shared types and constants for the sprite frame sequencer
// no dependencies; imported by every rtl file of the block

package sfs_pkg;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;
  localparam int RECT_W      = 20;
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_FRAME_WIDTH  = 3'd0,
    REG_FRAME_HEIGHT = 3'd1,
    REG_SHEET_COLS   = 3'd2,
    REG_LOOP_START   = 3'd3,
    REG_LOOP_END     = 3'd4,
    REG_FRAME_PERIOD = 3'd5
  } reg_index_t;

  typedef struct packed {
    logic [9:0]  frame_width;
    logic [9:0]  frame_height;
    logic [8:0]  sheet_columns;
    logic [7:0]  loop_start;
    logic [7:0]  loop_end;
    logic [15:0] frame_period;
  } cfg_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_DIV,
    B_MUL,
    B_SUM
  } back_state_t;

endpackage

### rtl/sfs_front.sv
// front end: accepts beats, updates frame counter and time accumulator
// depends on sfs_pkg; pushes the new frame index into sfs_queue

module sfs_front import sfs_pkg::*; #(
  parameter int INDEX_BITS = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  cfg_t                  cfg,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  kind,
  input  logic [15:0]           elapsed_ms,
  input  logic [7:0]            frame_index,
  input  logic                  queue_full,
  output logic                  push,
  output logic [INDEX_BITS-1:0] push_index
);

  localparam int WIDE = INDEX_BITS + 8;
  localparam logic [16:0] ACC_MAX = 17'h1FFFF;

  logic [INDEX_BITS-1:0] frame_counter, frame_counter_next;
  logic [16:0]           time_accumulator, time_accumulator_next;

  logic [17:0]     sum;
  logic [16:0]     sum_sat;
  logic [WIDE-1:0] inc_wide, start_wide, load_wide;

  assign in_ready = !queue_full;
  assign push     = in_valid && in_ready;

  always_comb begin
    sum        = 18'(time_accumulator) + 18'(elapsed_ms);
    sum_sat    = (sum > 18'(ACC_MAX)) ? ACC_MAX : sum[16:0];
    inc_wide   = WIDE'(frame_counter) + WIDE'(1);
    start_wide = WIDE'(cfg.loop_start);
    load_wide  = WIDE'(frame_index);
    frame_counter_next    = frame_counter;
    time_accumulator_next = time_accumulator;
    if (!kind) begin
      time_accumulator_next = sum_sat;
      if (sum_sat > 17'(cfg.frame_period)) begin
        time_accumulator_next = '0;
        // wrap test uses the full incremented value
        if (inc_wide > WIDE'(cfg.loop_end)) begin
          frame_counter_next = start_wide[INDEX_BITS-1:0];
        end else begin
          frame_counter_next = inc_wide[INDEX_BITS-1:0];
        end
      end
    end else begin
      frame_counter_next = load_wide[INDEX_BITS-1:0];
    end
  end

  assign push_index = frame_counter_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_counter    <= '0;
      time_accumulator <= '0;
    end else if (push) begin
      frame_counter    <= frame_counter_next;
      time_accumulator <= time_accumulator_next;
    end
  end

endmodule

### rtl/sfs_queue.sv
// short fifo of frame indexes between front and back end
// depends on sfs_pkg for the queue depth

module sfs_queue import sfs_pkg::*; #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty,
  output logic             full
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [WIDTH-1:0] slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;

  assign empty    = (count == '0);
  assign full     = (count == CNT_W'(QUEUE_DEPTH));
  assign pop_data = slots[rd_ptr];

  function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
    bump = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= bump(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= bump(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

### rtl/sfs_back.sv
// back end: restoring divide by column count, multiply, add, output register
// depends on sfs_pkg; pops frame indexes from sfs_queue

module sfs_back import sfs_pkg::*; #(
  parameter int INDEX_BITS = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  cfg_t                  cfg,
  input  logic                  queue_empty,
  input  logic [INDEX_BITS-1:0] queue_data,
  output logic                  pop,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [RECT_W-1:0]     rect_top,
  output logic [RECT_W-1:0]     rect_left,
  output logic [RECT_W-1:0]     rect_bottom,
  output logic [RECT_W-1:0]     rect_right,
  output logic [7:0]            current_frame
);

  localparam int CW = $clog2(INDEX_BITS + 1);
  localparam int PW = INDEX_BITS + 20;
  localparam int FW = INDEX_BITS + 8;

  back_state_t state, state_next;

  logic [INDEX_BITS-1:0] frame;
  logic [INDEX_BITS-1:0] dvd;
  logic [8:0]            rem;
  logic [CW-1:0]         cnt;
  logic [RECT_W-1:0]     top_p, left_p;

  logic [8:0]          cols_eff;
  logic [9:0]          trial;
  logic [9:0]          trial_sub;
  logic                qbit;
  logic [INDEX_BITS:0] dvd_sh;
  logic [PW-1:0]       row_prod;
  logic [PW-1:0]       col_prod;
  logic [FW-1:0]       frame_wide;
  logic                emit;

  // zero columns behave as one column
  assign cols_eff = (cfg.sheet_columns == '0) ? 9'd1 : cfg.sheet_columns;

  always_comb begin
    trial     = {rem, dvd[INDEX_BITS-1]};
    qbit      = (trial >= {1'b0, cols_eff});
    trial_sub = qbit ? (trial - {1'b0, cols_eff}) : trial;
    dvd_sh    = {dvd, qbit};
    row_prod  = PW'(dvd) * PW'(cfg.frame_height);
    col_prod  = PW'(rem) * PW'(cfg.frame_width);
    frame_wide = FW'(frame);
  end

  assign emit = (state == B_SUM) && (!out_valid || out_ready);

  always_comb begin
    state_next = state;
    pop        = 1'b0;
    case (state)
      B_IDLE: begin
        if (!queue_empty) begin
          pop        = 1'b1;
          state_next = B_DIV;
        end
      end
      B_DIV: begin
        if (cnt == CW'(1)) begin
          state_next = B_MUL;
        end
      end
      B_MUL: begin
        state_next = B_SUM;
      end
      B_SUM: begin
        if (emit) begin
          state_next = B_IDLE;
        end
      end
      default: begin
        state_next = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      B_IDLE: begin
        frame <= queue_data;
        dvd   <= queue_data;
        rem   <= '0;
        cnt   <= CW'(INDEX_BITS);
      end
      B_DIV: begin
        // one quotient bit per cycle, quotient shifts into dvd
        rem <= trial_sub[8:0];
        dvd <= dvd_sh[INDEX_BITS-1:0];
        cnt <= cnt - CW'(1);
      end
      B_MUL: begin
        top_p  <= row_prod[RECT_W-1:0];
        left_p <= col_prod[RECT_W-1:0];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      rect_top      <= top_p;
      rect_left     <= left_p;
      rect_bottom   <= top_p + RECT_W'(cfg.frame_height);
      rect_right    <= left_p + RECT_W'(cfg.frame_width);
      current_frame <= frame_wide[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

`ifndef SYNTHESIS
  a_div_count: assert property (@(posedge clk) disable iff (rst)
    state == B_DIV |-> cnt != '0)
    else $error("divide step count ran out");

  a_rem_range: assert property (@(posedge clk) disable iff (rst)
    state == B_MUL |-> rem < cols_eff)
    else $error("remainder not below column count");

  a_div_exact: assert property (@(posedge clk) disable iff (rst)
    state == B_MUL |->
      ((INDEX_BITS + 10)'(dvd) * (INDEX_BITS + 10)'(cols_eff)
       + (INDEX_BITS + 10)'(rem)) == (INDEX_BITS + 10)'(frame))
    else $error("quotient and remainder do not rebuild the frame index");

  a_hold_result: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(current_frame))
    else $error("waiting result dropped or changed");
`endif

endmodule

### rtl/sprite_frame_sequencer.sv
// sprite sheet animation sequencer, top level with configuration registers
// depends on sfs_pkg, sfs_front, sfs_queue and sfs_back
//
// usage:
//   input channel (in_valid/in_ready): one beat is a tick (kind = 0, elapsed_ms
//   added to the accumulator) or a frame set (kind = 1, frame_index loaded)
//   output channel (out_valid/out_ready): one beat per input beat, carrying the
//   source rectangle of the frame current after that input, plus its index
//   config: cfg_write with cfg_index / cfg_data sets a register;
//   write only while no beat is in flight; unknown indexes are ignored
// timing:
//   the front end updates frame state in the cycle a beat is accepted and
//   queues the index; the back end divides it by the column count one bit per
//   cycle, then multiplies and adds into the output register, and pops the
//   next index only after the current one is done
// reset: rst (synchronous) restores register defaults, frame 0, accumulator 0
// stall: a result waits in the output register while the back end finishes
//   the next one; the two-entry queue keeps in_ready high until it fills

module sprite_frame_sequencer import sfs_pkg::*; #(
  parameter int INDEX_BITS = 8
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic                   kind,
  input  logic [15:0]            elapsed_ms,
  input  logic [7:0]             frame_index,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [RECT_W-1:0]      rect_top,
  output logic [RECT_W-1:0]      rect_left,
  output logic [RECT_W-1:0]      rect_bottom,
  output logic [RECT_W-1:0]      rect_right,
  output logic [7:0]             current_frame
);

  cfg_t cfg;

  logic                  push, pop;
  logic [INDEX_BITS-1:0] push_index, pop_index;
  logic                  queue_empty, queue_full;

  // configuration registers, written in place, no read-back
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.frame_width   <= 10'd32;
      cfg.frame_height  <= 10'd32;
      cfg.sheet_columns <= 9'd1;
      cfg.loop_start    <= 8'd0;
      cfg.loop_end      <= 8'd0;
      cfg.frame_period  <= 16'd100;
    end else if (cfg_write) begin
      case (reg_index_t'(cfg_index))
        REG_FRAME_WIDTH:  cfg.frame_width   <= cfg_data[9:0];
        REG_FRAME_HEIGHT: cfg.frame_height  <= cfg_data[9:0];
        REG_SHEET_COLS:   cfg.sheet_columns <= cfg_data[8:0];
        REG_LOOP_START:   cfg.loop_start    <= cfg_data[7:0];
        REG_LOOP_END:     cfg.loop_end      <= cfg_data[7:0];
        REG_FRAME_PERIOD: cfg.frame_period  <= cfg_data[15:0];
        default: begin
        end
      endcase
    end
  end

  // front end: accept and update animation state
  sfs_front #(.INDEX_BITS(INDEX_BITS)) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .kind       (kind),
    .elapsed_ms (elapsed_ms),
    .frame_index(frame_index),
    .queue_full (queue_full),
    .push       (push),
    .push_index (push_index)
  );

  // decoupling queue of frame indexes
  sfs_queue #(.WIDTH(INDEX_BITS)) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_data(push_index),
    .pop      (pop),
    .pop_data (pop_index),
    .empty    (queue_empty),
    .full     (queue_full)
  );

  // back end: rectangle arithmetic and output register
  sfs_back #(.INDEX_BITS(INDEX_BITS)) u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .queue_empty  (queue_empty),
    .queue_data   (pop_index),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .rect_top     (rect_top),
    .rect_left    (rect_left),
    .rect_bottom  (rect_bottom),
    .rect_right   (rect_right),
    .current_frame(current_frame)
  );

endmodule

### bench/testbench.sv
// self-checking bench for sprite_frame_sequencer: directed and random beats
// depends on sfs_pkg and the sprite_frame_sequencer rtl; predicts every rect in-bench

module testbench import sfs_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  // beat kinds on the kind port
  localparam logic KIND_TICK = 1'b0;
  localparam logic KIND_SET  = 1'b1;

  // accumulator saturation point (17 bits)
  localparam int unsigned ACC_CEIL = 17'h1FFFF;

  // cycles to linger after the last result before the verdict
  localparam int SETTLE_CYCLES = 24;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_write = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic                   kind = KIND_TICK;
  logic [15:0]            elapsed_ms = '0;
  logic [7:0]             frame_index = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic [RECT_W-1:0]      rect_top;
  logic [RECT_W-1:0]      rect_left;
  logic [RECT_W-1:0]      rect_bottom;
  logic [RECT_W-1:0]      rect_right;
  logic [7:0]             current_frame;

  typedef struct {
    logic [RECT_W-1:0] top;
    logic [RECT_W-1:0] left;
    logic [RECT_W-1:0] bottom;
    logic [RECT_W-1:0] right;
    logic [7:0]        frame;
  } sprite_rect_t;

  // predicted animation state and register copy
  cfg_t         sheet_cfg;
  logic [7:0]   anim_frame;
  logic [16:0]  anim_acc;
  sprite_rect_t pending_rects[$];

  // idle knobs, percent of cycles
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned mismatches = 0;

  sprite_frame_sequencer u_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .kind         (kind),
    .elapsed_ms   (elapsed_ms),
    .frame_index  (frame_index),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .rect_top     (rect_top),
    .rect_left    (rect_left),
    .rect_bottom  (rect_bottom),
    .rect_right   (rect_right),
    .current_frame(current_frame)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // hard stop well past the slowest legal run
  initial begin
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

  task automatic flag_error(input string msg);
    $display("ERROR @%0t: %s", $time, msg);
    mismatches++;
  endtask

  function automatic cfg_t make_cfg(input int unsigned w, input int unsigned h,
                                    input int unsigned cols, input int unsigned first,
                                    input int unsigned last, input int unsigned period);
    cfg_t c;
    c.frame_width   = 10'(w);
    c.frame_height  = 10'(h);
    c.sheet_columns = 9'(cols);
    c.loop_start    = 8'(first);
    c.loop_end      = 8'(last);
    c.frame_period  = 16'(period);
    return c;
  endfunction

  // advance the predicted animation by one beat and return its rect
  function automatic sprite_rect_t next_frame_rect(input logic k, input logic [15:0] el,
                                                   input logic [7:0] idx);
    int unsigned  sum;
    int unsigned  next;
    int unsigned  cols;
    int unsigned  top;
    int unsigned  left;
    sprite_rect_t r;
    if (k == KIND_TICK) begin
      sum = anim_acc + el;
      if (sum > ACC_CEIL) sum = ACC_CEIL;
      anim_acc = 17'(sum);
      if (anim_acc > sheet_cfg.frame_period) begin
        // full incremented value is compared, so 255 always wraps
        next = anim_frame + 1;
        if (next > sheet_cfg.loop_end) next = sheet_cfg.loop_start;
        anim_frame = 8'(next);
        anim_acc = '0;
      end
    end else begin
      // frame set leaves the accumulator alone
      anim_frame = idx;
    end
    // zero columns behaves as a single column
    cols = (sheet_cfg.sheet_columns == 0) ? 1 : sheet_cfg.sheet_columns;
    top  = (anim_frame / cols) * sheet_cfg.frame_height;
    left = (anim_frame % cols) * sheet_cfg.frame_width;
    r.top    = RECT_W'(top);
    r.left   = RECT_W'(left);
    r.bottom = RECT_W'(top + sheet_cfg.frame_height);
    r.right  = RECT_W'(left + sheet_cfg.frame_width);
    r.frame  = anim_frame;
    return r;
  endfunction

  // one input beat; returns on the edge that accepted it, valid still high
  task automatic send_beat(input logic k, input logic [15:0] el, input logic [7:0] idx);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    kind        <= k;
    elapsed_ms  <= el;
    frame_index <= idx;
    do @(posedge clk); while (!in_ready);
    pending_rects.push_back(next_frame_rect(k, el, idx));
  endtask

  // drop valid and wait for every pending rect, then a little longer
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_rects.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // enable stays high across back-to-back writes
  task automatic write_reg(input reg_index_t idx, input logic [CFG_DATA_W-1:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
  endtask

  task automatic load_config(input cfg_t c);
    settle();
    sheet_cfg = c;
    write_reg(REG_FRAME_WIDTH,  CFG_DATA_W'(c.frame_width));
    write_reg(REG_FRAME_HEIGHT, CFG_DATA_W'(c.frame_height));
    write_reg(REG_SHEET_COLS,   CFG_DATA_W'(c.sheet_columns));
    write_reg(REG_LOOP_START,   CFG_DATA_W'(c.loop_start));
    write_reg(REG_LOOP_END,     CFG_DATA_W'(c.loop_end));
    write_reg(REG_FRAME_PERIOD, CFG_DATA_W'(c.frame_period));
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  // result side: compare each beat, then pick next cycle's ready
  always @(posedge clk) begin : rect_check
    sprite_rect_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_rects.size() == 0) begin
        flag_error($sformatf("result beat with no frame pending (frame %0d)", current_frame));
      end else begin
        want = pending_rects.pop_front();
        if (rect_top !== want.top)
          flag_error($sformatf("rect_top %0d, predicted %0d", rect_top, want.top));
        if (rect_left !== want.left)
          flag_error($sformatf("rect_left %0d, predicted %0d", rect_left, want.left));
        if (rect_bottom !== want.bottom)
          flag_error($sformatf("rect_bottom %0d, predicted %0d", rect_bottom, want.bottom));
        if (rect_right !== want.right)
          flag_error($sformatf("rect_right %0d, predicted %0d", rect_right, want.right));
        if (current_frame !== want.frame)
          flag_error($sformatf("current_frame %0d, predicted %0d", current_frame, want.frame));
      end
    end
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // reset register values: 32x32 frames, one column, loop 0..0, period 100
  task automatic test_reset_defaults();
    send_beat(KIND_TICK, 16'd0, 8'($urandom));
    send_beat(KIND_TICK, 16'd100, 8'($urandom));   // sum equals period, no advance
    send_beat(KIND_TICK, 16'd1, 8'($urandom));     // now exceeds, wraps to start
    send_beat(KIND_SET, 16'($urandom), 8'd255);
    send_beat(KIND_TICK, 16'hFFFF, 8'($urandom));  // 256 lies past the loop, wraps
  endtask

  // widest frames and sheet, zero period, full loop range
  task automatic test_max_extremes();
    load_config(make_cfg(1023, 1023, 256, 0, 255, 0));
    send_beat(KIND_SET, 16'($urandom), 8'd255);
    send_beat(KIND_TICK, 16'd0, 8'($urandom));     // zero elapsed never advances
    send_beat(KIND_TICK, 16'd1, 8'($urandom));     // top index wraps to start
    send_beat(KIND_TICK, 16'hFFFF, 8'($urandom));
    send_beat(KIND_SET, 16'h5555, 8'hAA);
    send_beat(KIND_SET, 16'hAAAA, 8'h55);
  endtask

  // zero columns acts as one column
  task automatic test_zero_columns();
    load_config(make_cfg(7, 9, 0, 3, 5, 10));
    send_beat(KIND_SET, 16'($urandom), 8'd200);
    send_beat(KIND_TICK, 16'd11, 8'($urandom));    // 201 past end, back to 3
    send_beat(KIND_TICK, 16'd11, 8'($urandom));
  endtask

  // accumulated time survives a frame set
  task automatic test_set_keeps_time();
    load_config(make_cfg(16, 24, 4, 2, 10, 100));
    send_beat(KIND_TICK, 16'd60, 8'($urandom));
    send_beat(KIND_SET, 16'($urandom), 8'd4);
    send_beat(KIND_TICK, 16'd41, 8'($urandom));    // 101 total, advances to 5
    send_beat(KIND_TICK, 16'd100, 8'($urandom));
  endtask

  // smallest frames, longest period, start above end
  task automatic test_min_extremes();
    load_config(make_cfg(1, 1, 1, 255, 0, 65535));
    send_beat(KIND_TICK, 16'hFFFF, 8'($urandom));  // carried 100 ms pushes past, to start
    send_beat(KIND_TICK, 16'hFFFF, 8'($urandom));  // equal to period, holds
    send_beat(KIND_TICK, 16'd1, 8'($urandom));     // exceeds, jumps to start
    send_beat(KIND_TICK, 16'hFFFF, 8'($urandom));  // equal again, holds
    send_beat(KIND_TICK, 16'hFFFF, 8'($urandom));  // largest possible sum
    send_beat(KIND_SET, 16'($urandom), 8'd0);
  endtask

  function automatic cfg_t random_cfg();
    int unsigned cols;
    int unsigned first;
    int unsigned last;
    int unsigned period;
    case ($urandom_range(3))
      0: cols = 1;
      1: cols = $urandom_range(1, 16);
      2: cols = $urandom_range(1, 256);
      default: cols = 256;
    endcase
    first = $urandom_range(255);
    last  = first + $urandom_range(24);
    if (last > 255) last = 255;
    // now and then an arbitrary, possibly inverted loop
    if ($urandom_range(99) < 15) last = $urandom_range(255);
    case ($urandom_range(9))
      0: period = 0;
      1: period = 65535;
      2: period = $urandom_range(65535);
      default: period = $urandom_range(300);
    endcase
    return make_cfg($urandom_range(1, 1023), $urandom_range(1, 1023), cols, first, last,
                    period);
  endfunction

  // ticks sized near the period so frames keep moving, plus loads and noise
  task automatic run_random_beats(input int count);
    int unsigned pick;
    int unsigned span;
    int unsigned idx;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      if (pick < 20) begin
        if ($urandom_range(1) == 0)
          idx = $urandom_range(255);
        else
          idx = $urandom_range(sheet_cfg.loop_start, 255);
        send_beat(KIND_SET, 16'($urandom), 8'(idx));
      end else if (pick < 85) begin
        span = sheet_cfg.frame_period + sheet_cfg.frame_period / 2 + 2;
        if (span > 65535) span = 65535;
        send_beat(KIND_TICK, 16'($urandom_range(span)), 8'($urandom));
      end else begin
        send_beat(KIND_TICK, 16'($urandom), 8'($urandom));
      end
    end
  endtask

  // four idle phases, two register settings each
  task automatic test_random_traffic();
    int unsigned send_pct[4] = '{0, 70, 0, 31};
    int unsigned recv_pct[4] = '{0, 0, 70, 31};
    for (int p = 0; p < 4; p++) begin
      for (int s = 0; s < 2; s++) begin
        load_config(random_cfg());
        send_idle_pct  = send_pct[p];
        recv_stall_pct = recv_pct[p];
        run_random_beats(100);
      end
    end
  endtask

  initial begin
    sheet_cfg  = make_cfg(32, 32, 1, 0, 0, 100);
    anim_frame = '0;
    anim_acc   = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_defaults();
    test_max_extremes();
    test_zero_columns();
    test_set_keeps_time();
    test_min_extremes();
    test_random_traffic();

    settle();
    if (mismatches == 0 && pending_rects.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
